/* rtl/rrwp_pkg.sv */
`timescale 1ns / 1ps

package rrwp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Number of tabulated arctangent entries; deeper pipelines stop here.
  localparam int ATAN_ENTRIES = 24;

  // CORDIC gain K in Q30, limit over infinitely many stages.
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  // Width of the signed distance: 16-bit range plus 16-bit signed offset.
  localparam int DIST_W = 18;

  // Integer bits above the fraction in the rotated x and y words.
  localparam int XW_GUARD = 19;

  // Residual angle width, 2^32 units per turn plus sign and headroom.
  localparam int ZW = 34;

  // Pose terms that ride along the pipeline beside the rotation.
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [32:0] pose_ys;
  } side_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/rrwp_front.sv */
`timescale 1ns / 1ps

module rrwp_front #(
  parameter int FRACTION_BITS = rrwp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      in_valid,
  input  logic [15:0]                               range_mm,
  input  logic [15:0]                               min_range_mm,
  input  logic [15:0]                               max_range_mm,
  input  logic signed [15:0]                        sensor_angle,
  input  logic signed [15:0]                        sensor_distance_mm,
  input  logic signed [15:0]                        sensor_y_offset_mm,
  input  logic signed [31:0]                        pose_x_mm,
  input  logic signed [31:0]                        pose_y_mm,
  input  logic signed [15:0]                        pose_heading,
  output logic                                      o_valid,
  output logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] o_x,
  output logic signed [rrwp_pkg::ZW-1:0]            o_z,
  output rrwp_pkg::side_t                           o_side
);

  localparam int XW    = FRACTION_BITS + rrwp_pkg::XW_GUARD;
  localparam int DW    = rrwp_pkg::DIST_W;
  localparam int PW    = DW + rrwp_pkg::GAIN_W + 1;
  localparam int SHIFT = 30 - FRACTION_BITS;

  // stage 1: range gate, distance, angle sum
  logic                 keep;
  logic signed [DW-1:0] dist_next;
  logic [15:0]          ang_next;
  rrwp_pkg::side_t      side_next;

  logic                 s1_valid;
  logic signed [DW-1:0] s1_dist;
  logic [15:0]          s1_ang;
  rrwp_pkg::side_t      s1_side;

  always_comb begin
    keep      = (range_mm > min_range_mm) && (range_mm < max_range_mm);
    dist_next = $signed({2'b00, range_mm}) + $signed({{2{sensor_distance_mm[15]}},
                                                      sensor_distance_mm});
    ang_next  = sensor_angle + pose_heading;
    side_next.pose_x  = pose_x_mm;
    side_next.pose_ys = $signed({pose_y_mm[31], pose_y_mm})
                      + $signed({{17{sensor_y_offset_mm[15]}}, sensor_y_offset_mm});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dist <= dist_next;
      s1_ang  <= ang_next;
      s1_side <= side_next;
    end
  end

  // stage 2: gain multiply, quadrant fold of the angle
  logic                     flip;
  logic [15:0]              ang_fold;
  logic [15:0]              ang_probe;
  logic signed [PW-1:0]     prod_next;

  logic                     s2_valid;
  logic                     s2_flip;
  logic signed [PW-1:0]     s2_prod;
  logic signed [rrwp_pkg::ZW-1:0] s2_z;
  rrwp_pkg::side_t          s2_side;

  always_comb begin
    ang_probe = s1_ang + 16'h4000;
    flip      = ang_probe[15];
    ang_fold  = s1_ang ^ {flip, 15'b0};
    prod_next = PW'(s1_dist) * $signed({1'b0, rrwp_pkg::GAIN_Q30});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flip <= flip;
      s2_prod <= prod_next;
      s2_z    <= rrwp_pkg::ZW'($signed({ang_fold, 16'b0}));
      s2_side <= s1_side;
    end
  end

  // stage 3: scale to the fraction format, negate for the folded half turn
  logic signed [XW-1:0] x_scaled;
  logic signed [XW-1:0] x_next;

  always_comb begin
    x_scaled = XW'(s2_prod >>> SHIFT);
    x_next   = s2_flip ? -x_scaled : x_scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x    <= x_next;
      o_z    <= s2_z;
      o_side <= s2_side;
    end
  end

endmodule

/* rtl/rrwp_cordic_stage.sv */
`timescale 1ns / 1ps

module rrwp_cordic_stage #(
  parameter int FRACTION_BITS = rrwp_pkg::FRACTION_BITS_DEF,
  parameter int IDX           = 0
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      i_valid,
  input  logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] i_x,
  input  logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] i_y,
  input  logic signed [rrwp_pkg::ZW-1:0]            i_z,
  input  rrwp_pkg::side_t                           i_side,
  output logic                                      o_valid,
  output logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] o_x,
  output logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] o_y,
  output logic signed [rrwp_pkg::ZW-1:0]            o_z,
  output rrwp_pkg::side_t                           o_side
);

  localparam int XW = FRACTION_BITS + rrwp_pkg::XW_GUARD;
  localparam logic signed [rrwp_pkg::ZW-1:0] ATAN =
    $signed({2'b00, rrwp_pkg::atan_turn(5'(IDX))});

  logic signed [XW-1:0]           dx;
  logic signed [XW-1:0]           dy;
  logic signed [XW-1:0]           x_next;
  logic signed [XW-1:0]           y_next;
  logic signed [rrwp_pkg::ZW-1:0] z_next;

  // rotate toward zero residual angle; arithmetic shift is the floor
  always_comb begin
    dx = i_y >>> IDX;
    dy = i_x >>> IDX;
    if (!i_z[rrwp_pkg::ZW-1]) begin
      x_next = i_x - dx;
      y_next = i_y + dy;
      z_next = i_z - ATAN;
    end else begin
      x_next = i_x + dx;
      y_next = i_y - dy;
      z_next = i_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x    <= x_next;
      o_y    <= y_next;
      o_z    <= z_next;
      o_side <= i_side;
    end
  end

endmodule

/* rtl/rrwp_back.sv */
`timescale 1ns / 1ps

module rrwp_back #(
  parameter int FRACTION_BITS = rrwp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      i_valid,
  input  logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] i_x,
  input  logic signed [FRACTION_BITS+rrwp_pkg::XW_GUARD-1:0] i_y,
  input  rrwp_pkg::side_t                           i_side,
  output logic                                      o_valid,
  output logic signed [31:0]                        o_point_x,
  output logic signed [31:0]                        o_point_y
);

  localparam int FW = FRACTION_BITS + 35;
  localparam int QW = FW - FRACTION_BITS;

  // stage A: add pose in the fixed-point domain
  logic                 sa_valid;
  logic signed [FW-1:0] sa_x;
  logic signed [FW-1:0] sa_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (adv) begin
      sa_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_x <= FW'(i_x) + (FW'(i_side.pose_x) <<< FRACTION_BITS);
      sa_y <= FW'(i_y) + (FW'(i_side.pose_ys) <<< FRACTION_BITS);
    end
  end

  // stage B: truncate toward zero, then saturate to 32 bits
  function automatic logic signed [31:0] finish(input logic signed [FW-1:0] v);
    logic signed [QW-1:0] q;
    logic                 round_up;
    logic signed [31:0]   res;
    round_up = v[FW-1] && (|v[FRACTION_BITS-1:0]);
    q = QW'(v >>> FRACTION_BITS) + QW'(round_up);
    if (!q[QW-1] && (|q[QW-2:31])) begin
      res = 32'sh7FFF_FFFF;
    end else if (q[QW-1] && !(&q[QW-2:31])) begin
      res = 32'sh8000_0000;
    end else begin
      res = q[31:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_point_x <= finish(sa_x);
      o_point_y <= finish(sa_y);
    end
  end

endmodule

/* rtl/range_reading_to_world_point.sv */
`timescale 1ns / 1ps
// Range reading to world point.
// Input channel (in_valid / in_ready): one word per reading, carrying the
// range, its exclusive min/max limits, the sensor mounting geometry and the
// robot pose. Output channel (out_valid / out_ready): one world point word
// (point_x_mm, point_y_mm) per reading whose range lies strictly inside the
// limits; rejected readings just drop out of the pipeline.
// Pipeline: three front stages (range gate and angle sum, gain multiply and
// quadrant fold, scale and negate), one register per CORDIC micro-rotation,
// and two back stages (pose add, truncate and saturate). The last back
// stage is the output register.
// Throughput is one reading per cycle: every stage takes a new word each
// cycle the pipeline advances.
// When the receiver stalls with a word waiting, the whole pipeline holds;
// in_ready drops in the same cycle and nothing is lost or repeated.
// Reset (rst, synchronous) clears all stage valid bits; the pipeline comes
// out of reset empty and ready. No state survives between readings.

module range_reading_to_world_point #(
  parameter int CORDIC_STAGES = rrwp_pkg::CORDIC_STAGES_DEF,
  parameter int FRACTION_BITS = rrwp_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        range_mm,
  input  logic [15:0]        min_range_mm,
  input  logic [15:0]        max_range_mm,
  input  logic signed [15:0] sensor_angle,
  input  logic signed [15:0] sensor_distance_mm,
  input  logic signed [15:0] sensor_y_offset_mm,
  input  logic signed [31:0] pose_x_mm,
  input  logic signed [31:0] pose_y_mm,
  input  logic signed [15:0] pose_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x_mm,
  output logic signed [31:0] point_y_mm
);

  // Only the tabulated micro-rotations are built.
  localparam int NS = (CORDIC_STAGES > rrwp_pkg::ATAN_ENTRIES) ?
                      rrwp_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int XW = FRACTION_BITS + rrwp_pkg::XW_GUARD;
  localparam int ZW = rrwp_pkg::ZW;

  // Residual angle bound after the last micro-rotation, with margin for
  // table rounding.
  localparam logic signed [ZW-1:0] Z_BOUND =
    $signed({1'b0, rrwp_pkg::atan_turn(5'(NS - 1)), 1'b0});

  // Advance the whole pipeline unless a finished word is held at the output.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage taps of the rotation chain; tap 0 is the front-end output.
  logic                 cvalid [0:NS];
  logic signed [XW-1:0] cx     [0:NS];
  logic signed [XW-1:0] cy     [0:NS];
  logic signed [ZW-1:0] cz     [0:NS];
  rrwp_pkg::side_t      cside  [0:NS];

  // Front end: gate, distance, angle sum, gain multiply, quadrant fold, scale.
  rrwp_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .adv                (adv),
    .in_valid           (in_valid),
    .range_mm           (range_mm),
    .min_range_mm       (min_range_mm),
    .max_range_mm       (max_range_mm),
    .sensor_angle       (sensor_angle),
    .sensor_distance_mm (sensor_distance_mm),
    .sensor_y_offset_mm (sensor_y_offset_mm),
    .pose_x_mm          (pose_x_mm),
    .pose_y_mm          (pose_y_mm),
    .pose_heading       (pose_heading),
    .o_valid            (cvalid[0]),
    .o_x                (cx[0]),
    .o_z                (cz[0]),
    .o_side             (cside[0])
  );

  // y starts at zero; the rotation builds it.
  assign cy[0] = '0;

  // One registered micro-rotation per stage.
  for (genvar g = 0; g < NS; g++) begin : g_cordic
    rrwp_cordic_stage #(
      .FRACTION_BITS (FRACTION_BITS),
      .IDX           (g)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .i_valid (cvalid[g]),
      .i_x     (cx[g]),
      .i_y     (cy[g]),
      .i_z     (cz[g]),
      .i_side  (cside[g]),
      .o_valid (cvalid[g+1]),
      .o_x     (cx[g+1]),
      .o_y     (cy[g+1]),
      .o_z     (cz[g+1]),
      .o_side  (cside[g+1])
    );
  end

  // Back end: pose add, then truncate and saturate into the output register.
  rrwp_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .i_valid   (cvalid[NS]),
    .i_x       (cx[NS]),
    .i_y       (cy[NS]),
    .i_side    (cside[NS]),
    .o_valid   (out_valid),
    .o_point_x (point_x_mm),
    .o_point_y (point_y_mm)
  );

  // A stall must freeze a word sitting at the end of the rotation chain.
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && cvalid[NS]) |=> (cvalid[NS] && $stable(cx[NS]) && $stable(cy[NS])))
    else $error("rotation chain word changed during stall");

  // The rotation must have driven the residual angle close to zero.
  a_angle_converged: assert property (@(posedge clk) disable iff (rst)
    cvalid[NS] |-> ((cz[NS] <= Z_BOUND) && (cz[NS] >= -Z_BOUND)))
    else $error("CORDIC residual angle did not converge");

  // A word only reaches the output from a valid word at the chain end.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(cvalid[NS], 2))
    else $error("output word without a source in the rotation chain");

endmodule
